// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge while out of reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/i2p_pkg.sv =====
// ----------------------------------------------------------------------------
// i2p_pkg
// shared types, character codes and classification helpers
// ----------------------------------------------------------------------------
package i2p_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_D0     = 8'h30;
    localparam logic [7:0] CH_D9     = 8'h39;

    // result status codes
    localparam logic [1:0] ST_CHAR      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;

    // item classes
    localparam logic [1:0] CLS_OPERAND = 2'd0;
    localparam logic [1:0] CLS_OPEN    = 2'd1;
    localparam logic [1:0] CLS_CLOSE   = 2'd2;
    localparam logic [1:0] CLS_OPER    = 2'd3;

    // command queue depth
    localparam int CMDQ_DEPTH = 2;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] cls;
        logic [1:0] prec;
        logic       lead;     // close an operand run first
        logic       trail;    // close an operand run at the end
        logic       last_in;  // final item of the expression
    } cmd_t;

    function automatic logic is_operand(input logic [7:0] c);
        return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
               (c >= CH_D0 && c <= CH_D9);
    endfunction

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_CARET)
            p = 2'd3;
        else if (c == CH_STAR || c == CH_SLASH)
            p = 2'd2;
        else if (c == CH_PLUS || c == CH_MINUS)
            p = 2'd1;
        return p;
    endfunction

endpackage

// ===== src/i2p_front.sv =====
// ----------------------------------------------------------------------------
// i2p_front
// accepts input items, tracks operand runs and classifies each character
// ----------------------------------------------------------------------------
module i2p_front
    import i2p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] in_char,
    input  logic       end_of_expr,
    output logic       full,
    input  logic       q_full,
    output logic       q_wr,
    output cmd_t       q_cmd
);

    logic run_reg;
    logic run_next;
    logic opnd;

    assign opnd = is_operand(in_char);
    assign full = q_full;
    assign q_wr = push && !q_full;

    always_comb
    begin
        q_cmd.ch      = in_char;
        q_cmd.prec    = prec_of(in_char);
        q_cmd.lead    = !opnd && run_reg;
        q_cmd.trail   = end_of_expr && opnd;
        q_cmd.last_in = end_of_expr;
        if (opnd)
            q_cmd.cls = CLS_OPERAND;
        else if (in_char == CH_LPAREN)
            q_cmd.cls = CLS_OPEN;
        else if (in_char == CH_RPAREN)
            q_cmd.cls = CLS_CLOSE;
        else
            q_cmd.cls = CLS_OPER;
    end

    // run stays open only across operand characters inside an expression
    assign run_next = q_wr ? (opnd && !end_of_expr) : run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= 1'b0;
        else
            run_reg <= run_next;
    end

endmodule

// ===== src/i2p_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// i2p_cmd_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module i2p_cmd_queue
    import i2p_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wr_cmd,
    output logic q_full,
    input  logic rd,
    output logic q_empty,
    output cmd_t rd_cmd
);

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(CMDQ_DEPTH - 1);

    cmd_t          mem_reg [CMDQ_DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (cnt_reg == CW'(CMDQ_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_cmd  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == LAST) ? '0 : wp_reg + PW'(1);
            if (do_rd)
                rp_reg <= (rp_reg == LAST) ? '0 : rp_reg + PW'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + CW'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_cmd;
    end

endmodule

// ===== src/i2p_back.sv =====
// ----------------------------------------------------------------------------
// i2p_back
// operator stack sequencer, one command at a time, with hold and output stage
// ----------------------------------------------------------------------------
module i2p_back
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_cmd,
    output logic       q_rd,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_char,
    output logic [1:0] status,
    output logic       run_last,
    output logic       expr_done
);

    localparam int IDXW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW   = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_LEAD  = 3'd1;
    localparam logic [2:0] B_MAIN  = 3'd2;
    localparam logic [2:0] B_SPACE = 3'd3;
    localparam logic [2:0] B_TAIL  = 3'd4;
    localparam logic [2:0] B_FLUSH = 3'd5;
    localparam logic [2:0] B_FIN   = 3'd6;

    logic [7:0]      stk_reg [STACK_DEPTH];
    logic [CW-1:0]   cnt_reg;
    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    logic            spc_flush_reg;
    logic            spc_flush_next;
    cmd_t            cmd_reg;

    logic            hold_valid_reg;
    logic            hold_valid_next;
    logic [7:0]      hold_char_reg;
    logic [1:0]      hold_status_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [7:0]      out_char_reg;
    logic [1:0]      out_status_reg;
    logic            out_last_reg;
    logic            out_done_reg;

    logic [IDXW-1:0] top_idx;
    logic [7:0]      top_char;
    logic            stk_full;
    logic            stk_any;
    logic            can_pop_op;
    logic [2:0]      after_main;
    logic [2:0]      first_state;

    logic            gen;
    logic [7:0]      gen_char;
    logic [1:0]      gen_status;
    logic            do_push;
    logic            do_pop;
    logic            load_cmd;
    logic            fin_out;
    logic            out_pop;
    logic            out_free;
    logic            adv;
    logic            out_load;
    logic            hold_load;

    assign top_idx    = IDXW'(cnt_reg - CW'(1));
    assign top_char   = stk_reg[top_idx];
    assign stk_full   = (cnt_reg == CW'(STACK_DEPTH));
    assign stk_any    = (cnt_reg != '0);
    assign can_pop_op = stk_any && (top_char != CH_LPAREN) &&
                        (prec_of(top_char) >= cmd_reg.prec);
    assign after_main = cmd_reg.last_in ? B_TAIL : B_FIN;
    assign first_state = q_cmd.lead ? B_LEAD : B_MAIN;

    always_comb
    begin
        gen            = 1'b0;
        gen_char       = CH_SPACE;
        gen_status     = ST_CHAR;
        do_push        = 1'b0;
        do_pop         = 1'b0;
        load_cmd       = 1'b0;
        fin_out        = 1'b0;
        spc_flush_next = spc_flush_reg;
        state_next     = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    load_cmd   = 1'b1;
                    state_next = first_state;
                end
            end
            B_LEAD:
            begin
                gen        = 1'b1;
                state_next = B_MAIN;
            end
            B_MAIN:
            begin
                unique case (cmd_reg.cls)
                    CLS_OPERAND:
                    begin
                        gen        = 1'b1;
                        gen_char   = cmd_reg.ch;
                        state_next = after_main;
                    end
                    CLS_OPEN:
                    begin
                        if (stk_full)
                        begin
                            gen        = 1'b1;
                            gen_char   = CH_NUL;
                            gen_status = ST_OVERFLOW;
                        end
                        else
                            do_push = 1'b1;
                        state_next = after_main;
                    end
                    CLS_CLOSE:
                    begin
                        if (stk_any && top_char != CH_LPAREN)
                        begin
                            gen            = 1'b1;
                            gen_char       = top_char;
                            do_pop         = 1'b1;
                            spc_flush_next = 1'b0;
                            state_next     = B_SPACE;
                        end
                        else if (stk_any)
                        begin
                            // matching open parenthesis leaves silently
                            do_pop     = 1'b1;
                            state_next = after_main;
                        end
                        else
                        begin
                            gen        = 1'b1;
                            gen_char   = CH_NUL;
                            gen_status = ST_UNMATCHED;
                            state_next = after_main;
                        end
                    end
                    CLS_OPER:
                    begin
                        if (can_pop_op)
                        begin
                            gen            = 1'b1;
                            gen_char       = top_char;
                            do_pop         = 1'b1;
                            spc_flush_next = 1'b0;
                            state_next     = B_SPACE;
                        end
                        else
                        begin
                            if (stk_full)
                            begin
                                gen        = 1'b1;
                                gen_char   = CH_NUL;
                                gen_status = ST_OVERFLOW;
                            end
                            else
                                do_push = 1'b1;
                            state_next = after_main;
                        end
                    end
                endcase
            end
            B_SPACE:
            begin
                gen        = 1'b1;
                state_next = spc_flush_reg ? B_FLUSH : B_MAIN;
            end
            B_TAIL:
            begin
                gen        = cmd_reg.trail;
                state_next = B_FLUSH;
            end
            B_FLUSH:
            begin
                if (stk_any)
                begin
                    gen            = 1'b1;
                    gen_char       = top_char;
                    do_pop         = 1'b1;
                    spc_flush_next = 1'b1;
                    state_next     = B_SPACE;
                end
                else
                    state_next = B_FIN;
            end
            B_FIN:
            begin
                // an expression end with nothing held still shows one space
                fin_out = hold_valid_reg || cmd_reg.last_in;
                if (!q_empty)
                begin
                    load_cmd   = 1'b1;
                    state_next = first_state;
                end
                else
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign out_pop  = pop && out_valid_reg;
    assign out_free = !out_valid_reg || out_pop;

    always_comb
    begin
        if (gen)
            adv = !hold_valid_reg || out_free;
        else if (fin_out)
            adv = out_free;
        else
            adv = 1'b1;
    end

    assign q_rd      = load_cmd && adv;
    assign hold_load = adv && gen;
    assign out_load  = adv && ((gen && hold_valid_reg) || fin_out);

    assign hold_valid_next = hold_load ? 1'b1 : (out_load ? 1'b0 : hold_valid_reg);
    assign out_valid_next  = out_load ? 1'b1 : (out_pop ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            spc_flush_reg  <= 1'b0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                state_reg     <= state_next;
                spc_flush_reg <= spc_flush_next;
                if (do_push)
                    cnt_reg <= cnt_reg + CW'(1);
                else if (do_pop)
                    cnt_reg <= cnt_reg - CW'(1);
            end
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
            cmd_reg <= q_cmd;
        if (adv && do_push)
            stk_reg[cnt_reg[IDXW-1:0]] <= cmd_reg.ch;
        if (hold_load)
        begin
            hold_char_reg   <= gen_char;
            hold_status_reg <= gen_status;
        end
        if (out_load)
        begin
            out_char_reg   <= hold_valid_reg ? hold_char_reg : CH_SPACE;
            out_status_reg <= hold_valid_reg ? hold_status_reg : ST_CHAR;
            out_last_reg   <= fin_out;
            out_done_reg   <= fin_out && cmd_reg.last_in;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_char  = out_char_reg;
    assign status    = out_status_reg;
    assign run_last  = out_last_reg;
    assign expr_done = out_done_reg;

endmodule

// ===== src/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// shunting-yard conversion of an infix character stream to postfix
// ----------------------------------------------------------------------------
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------
//  input    | push / full      | in_char[7:0], end_of_expr
//  result   | pop / empty      | out_char[7:0], status[1:0], run_last,
//           |                  | expr_done
//
//  the back sequencer takes an operand or a plain push through its main and
//  finish states (idle first when it starts from idle); a lead state adds the
//  space that closes an operand run, each popped operator a space state, an
//  expression end the tail and flush states and a space per flushed entry;
//  it emits at most one result per cycle while no stalled result holds it
//  the front keeps taking items while the command queue has room
//  rst_n clears the operand run, the stack count, the queue and all valid
//  flags; stack contents are not cleared
//  a stalled result holds the back once its hold stage is also full, or when
//  an expression end with nothing held must show its lone space
//
`include "assert_macros.svh"

module infix_to_postfix_converter
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input items
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_char,
    input  logic       end_of_expr,
    // result items
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic [1:0] status,
    output logic       run_last,
    output logic       expr_done
);

    // front to queue
    logic q_wr;
    cmd_t q_wcmd;
    logic q_full;
    // queue to back
    logic q_rd;
    logic q_empty;
    cmd_t q_rcmd;

    // classification and operand run tracking
    i2p_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .in_char     (in_char),
        .end_of_expr (end_of_expr),
        .full        (full),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .q_cmd       (q_wcmd)
    );

    // decouples input acceptance from the stack work
    i2p_cmd_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_cmd  (q_wcmd),
        .q_full  (q_full),
        .rd      (q_rd),
        .q_empty (q_empty),
        .rd_cmd  (q_rcmd)
    );

    // operator stack, result sequencing and output stage
    i2p_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (q_rcmd),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .out_char  (out_char),
        .status    (status),
        .run_last  (run_last),
        .expr_done (expr_done)
    );

    // the end of an expression is always the last result of its item
    `ASSERT_RST(a_done_is_last, clk, rst_n, (!empty && expr_done) |-> run_last,
                "expr_done without run_last")
    // error results carry no character
    `ASSERT_RST(a_err_no_char, clk, rst_n,
                (!empty && status != ST_CHAR) |-> (out_char == CH_NUL),
                "error result with character")
    // only the three defined status codes appear
    `ASSERT_RST(a_status_code, clk, rst_n, !empty |-> (status != 2'd3),
                "undefined status code")
    // input back pressure only comes from pending commands
    `ASSERT_ALWAYS(a_full_busy, clk, full |-> !q_empty, "full with empty command queue")

endmodule
